// File: hdl/triangle_unit_normal_defines.svh
// Assertion macros for the triangle unit normal block and its checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TUN_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed: lbl");

// The consequent must hold in the cycle after the antecedent.
`define TUN_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed: lbl");

`endif

// File: hdl/tun_pkg.sv
// Shared constants and word types of the triangle unit normal block.
// No dependencies; used by the top level and by its checker.
`default_nettype none
package tun_pkg;

    localparam int COORD_WIDTH      = 24;
    localparam int NORMAL_FRAC_BITS = 15;

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = CROSS_W - 1;
    localparam int HALF_W  = (MAG_W + 1) / 2;
    localparam int HI_W    = MAG_W - HALF_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int WORK_W  = SQ_W + 2 * NORMAL_FRAC_BITS + 8;
    localparam int OUT_W   = NORMAL_FRAC_BITS + 1;
    localparam int NUM_BITS = NORMAL_FRAC_BITS + 1;
    // Six front stages, the start stage, one stage per quotient bit, the output stage.
    localparam int NUM_STAGES = 6 + NUM_BITS + 2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] first_z;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
        logic signed [COORD_WIDTH-1:0] second_z;
        logic signed [COORD_WIDTH-1:0] third_x;
        logic signed [COORD_WIDTH-1:0] third_y;
        logic signed [COORD_WIDTH-1:0] third_z;
    } tri_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } nrm_word_t;

endpackage
`default_nettype wire

// File: hdl/triangle_unit_normal.sv
// Triangle unit normal: pipelined cross product and exact normalization.
// Depends on tun_pkg for widths and word types.
`default_nettype none

// The block takes one triangle word per clock while tri_stall is low and
// returns its unit plane normal in signed Q1.15: six stages form edge
// vectors, cross products, magnitudes and exact squared lengths, one stage
// sets up the division, one stage per quotient bit finds each rounded
// component, and a final stage applies sign and saturation. The quotient is
// solved digit by digit as the largest q with
// (2q-1)^2 * |c|^2 <= 4 * c_i^2 * 2^(2F), so the result is rounded to
// nearest, ties away from zero, with no square root error.
// A component of exactly +1.0 saturates to 32767. A zero cross product
// gives zero components and raises degenerate. Valid bits travel with the
// data; a stall on the output holds only the stages that are full, so
// bubbles close up and input words keep flowing while a result waits,
// until every stage is full.
module triangle_unit_normal (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tri_valid,
    output logic                   tri_stall,
    input  wire tun_pkg::tri_word_t tri_word,
    output logic                   nrm_valid,
    input  wire logic              nrm_stall,
    output tun_pkg::nrm_word_t     nrm_word
);

    // Stage valid bits and the hold chain that runs back from the output.
    logic [tun_pkg::NUM_STAGES-1:0] vld_reg;
    logic [tun_pkg::NUM_STAGES-1:0] hold;

    always_comb
    begin
        hold[tun_pkg::NUM_STAGES-1] = vld_reg[tun_pkg::NUM_STAGES-1] & nrm_stall;
        for (int i = tun_pkg::NUM_STAGES - 2; i >= 0; i--)
        begin
            hold[i] = vld_reg[i] & hold[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (!hold[0])
            begin
                vld_reg[0] <= tri_valid;
            end
            for (int i = 1; i < tun_pkg::NUM_STAGES; i++)
            begin
                if (!hold[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign tri_stall = hold[0];
    assign nrm_valid = vld_reg[tun_pkg::NUM_STAGES-1];

    // Stage 0: edge vectors v = second - first and w = third - first.
    logic signed [tun_pkg::COORD_WIDTH-1:0] pa [3];
    logic signed [tun_pkg::COORD_WIDTH-1:0] pb [3];
    logic signed [tun_pkg::COORD_WIDTH-1:0] pd [3];
    logic signed [tun_pkg::DIFF_W-1:0] ev_reg [3];
    logic signed [tun_pkg::DIFF_W-1:0] ew_reg [3];

    always_comb
    begin
        pa[0] = tri_word.first_x;  pa[1] = tri_word.first_y;  pa[2] = tri_word.first_z;
        pb[0] = tri_word.second_x; pb[1] = tri_word.second_y; pb[2] = tri_word.second_z;
        pd[0] = tri_word.third_x;  pd[1] = tri_word.third_y;  pd[2] = tri_word.third_z;
    end

    always_ff @(posedge clk)
    begin
        if (!hold[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                ev_reg[i] <= tun_pkg::DIFF_W'(pb[i]) - tun_pkg::DIFF_W'(pa[i]);
                ew_reg[i] <= tun_pkg::DIFF_W'(pd[i]) - tun_pkg::DIFF_W'(pa[i]);
            end
        end
    end

    // Stage 1: the two products of each cross product component.
    logic signed [tun_pkg::PROD_W-1:0] pp_reg [3];
    logic signed [tun_pkg::PROD_W-1:0] pm_reg [3];

    always_ff @(posedge clk)
    begin
        if (!hold[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pp_reg[i] <= ev_reg[(i + 1) % 3] * ew_reg[(i + 2) % 3];
                pm_reg[i] <= ev_reg[(i + 2) % 3] * ew_reg[(i + 1) % 3];
            end
        end
    end

    // Stage 2: cross product, split into sign and magnitude.
    logic signed [tun_pkg::CROSS_W-1:0] cr [3];
    logic        [tun_pkg::CROSS_W-1:0] cr_abs [3];
    logic [tun_pkg::MAG_W-1:0] mag_reg [3];
    logic [2:0]                neg2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cr[i]     = tun_pkg::CROSS_W'(pp_reg[i]) - tun_pkg::CROSS_W'(pm_reg[i]);
            cr_abs[i] = cr[i][tun_pkg::CROSS_W-1] ? -cr[i] : cr[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]  <= cr_abs[i][tun_pkg::MAG_W-1:0];
                neg2_reg[i] <= cr[i][tun_pkg::CROSS_W-1];
            end
        end
    end

    // Stage 3: partial products of each squared magnitude.
    logic [2*tun_pkg::HI_W-1:0]                 hh_reg [3];
    logic [tun_pkg::HI_W+tun_pkg::HALF_W-1:0]   hl_reg [3];
    logic [2*tun_pkg::HALF_W-1:0]               ll_reg [3];
    logic [2:0]                                 neg3_reg;

    always_ff @(posedge clk)
    begin
        if (!hold[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                hh_reg[i] <= mag_reg[i][tun_pkg::MAG_W-1:tun_pkg::HALF_W]
                           * mag_reg[i][tun_pkg::MAG_W-1:tun_pkg::HALF_W];
                hl_reg[i] <= mag_reg[i][tun_pkg::MAG_W-1:tun_pkg::HALF_W]
                           * mag_reg[i][tun_pkg::HALF_W-1:0];
                ll_reg[i] <= mag_reg[i][tun_pkg::HALF_W-1:0]
                           * mag_reg[i][tun_pkg::HALF_W-1:0];
            end
            neg3_reg <= neg2_reg;
        end
    end

    // Stage 4: squared magnitudes.
    logic [tun_pkg::SQ_W-1:0] msq_reg [3];
    logic [2:0]               neg4_reg;

    always_ff @(posedge clk)
    begin
        if (!hold[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                msq_reg[i] <= (tun_pkg::SQ_W'(hh_reg[i]) << (2 * tun_pkg::HALF_W))
                            + (tun_pkg::SQ_W'(hl_reg[i]) << (tun_pkg::HALF_W + 1))
                            + tun_pkg::SQ_W'(ll_reg[i]);
            end
            neg4_reg <= neg3_reg;
        end
    end

    // Stage 5: squared length of the cross product.
    logic [tun_pkg::SUM_W-1:0] sum_reg;
    logic [tun_pkg::SQ_W-1:0]  msq5_reg [3];
    logic [2:0]                neg5_reg;

    always_ff @(posedge clk)
    begin
        if (!hold[5])
        begin
            sum_reg  <= tun_pkg::SUM_W'(msq_reg[0]) + tun_pkg::SUM_W'(msq_reg[1])
                      + tun_pkg::SUM_W'(msq_reg[2]);
            msq5_reg <= msq_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // Division stages. Slot 0 is the start stage; slot j+1 settles quotient
    // bit F-j. Each lane keeps the remainder D = R - (u-1)^2 * S and the
    // running term G = (u-1) * S, with u = 2q, so a trial bit costs shifts
    // and one three-input add.
    logic signed [tun_pkg::WORK_W-1:0] dr_reg [tun_pkg::NUM_BITS+1][3];
    logic signed [tun_pkg::WORK_W-1:0] gt_reg [tun_pkg::NUM_BITS+1][3];
    logic [tun_pkg::OUT_W-1:0]         qt_reg [tun_pkg::NUM_BITS+1][3];
    logic signed [tun_pkg::WORK_W-1:0] sl_reg [tun_pkg::NUM_BITS+1];
    logic [2:0]                        ng_reg [tun_pkg::NUM_BITS+1];
    logic                              dg_reg [tun_pkg::NUM_BITS+1];

    logic signed [tun_pkg::WORK_W-1:0] s_ext;
    logic signed [tun_pkg::WORK_W-1:0] r_ext [3];

    always_comb
    begin
        s_ext = tun_pkg::WORK_W'(sum_reg);
        for (int i = 0; i < 3; i++)
        begin
            r_ext[i] = tun_pkg::WORK_W'(msq5_reg[i]) <<< (2 * tun_pkg::NORMAL_FRAC_BITS + 2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold[6])
        begin
            for (int i = 0; i < 3; i++)
            begin
                dr_reg[0][i] <= r_ext[i] - s_ext;
                gt_reg[0][i] <= -s_ext;
                qt_reg[0][i] <= '0;
            end
            sl_reg[0] <= s_ext;
            ng_reg[0] <= neg5_reg;
            dg_reg[0] <= (sum_reg == '0);
        end
    end

    for (genvar j = 0; j < tun_pkg::NUM_BITS; j++)
    begin : g_bit
        logic signed [tun_pkg::WORK_W-1:0] trial [3];
        logic [2:0]                        take;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = dr_reg[j][i]
                         - (gt_reg[j][i] <<< (tun_pkg::NORMAL_FRAC_BITS - j + 2))
                         - (sl_reg[j] <<< (2 * (tun_pkg::NORMAL_FRAC_BITS - j) + 2));
                take[i]  = ~trial[i][tun_pkg::WORK_W-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!hold[7 + j])
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dr_reg[j+1][i] <= take[i] ? trial[i] : dr_reg[j][i];
                    gt_reg[j+1][i] <= take[i]
                        ? gt_reg[j][i] + (sl_reg[j] <<< (tun_pkg::NORMAL_FRAC_BITS - j + 1))
                        : gt_reg[j][i];
                    qt_reg[j+1][i] <= qt_reg[j][i]
                        | (tun_pkg::OUT_W'(take[i]) << (tun_pkg::NORMAL_FRAC_BITS - j));
                end
                sl_reg[j+1] <= sl_reg[j];
                ng_reg[j+1] <= ng_reg[j];
                dg_reg[j+1] <= dg_reg[j];
            end
        end
    end

    // Output stage: sign, saturation of +1.0 and the degenerate case.
    logic [tun_pkg::OUT_W-1:0] comp [3];
    tun_pkg::nrm_word_t        nrm_next;
    tun_pkg::nrm_word_t        nrm_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dg_reg[tun_pkg::NUM_BITS])
            begin
                comp[i] = '0;
            end
            else if (ng_reg[tun_pkg::NUM_BITS][i])
            begin
                comp[i] = -qt_reg[tun_pkg::NUM_BITS][i];
            end
            else if (qt_reg[tun_pkg::NUM_BITS][i][tun_pkg::OUT_W-1])
            begin
                comp[i] = {1'b0, {(tun_pkg::OUT_W-1){1'b1}}};
            end
            else
            begin
                comp[i] = qt_reg[tun_pkg::NUM_BITS][i];
            end
        end
        nrm_next.normal_x   = comp[0];
        nrm_next.normal_y   = comp[1];
        nrm_next.normal_z   = comp[2];
        nrm_next.degenerate = dg_reg[tun_pkg::NUM_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (!hold[tun_pkg::NUM_STAGES-1])
        begin
            nrm_reg <= nrm_next;
        end
    end

    assign nrm_word = nrm_reg;

endmodule
`default_nettype wire

// File: hdl/tun_checker.sv
// Port-level checks for the triangle unit normal block, bound to its top level.
// Depends on tun_pkg and on the assertion macros in the defines header.
`default_nettype none
`include "triangle_unit_normal_defines.svh"

module tun_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               tri_valid,
    input wire logic               tri_stall,
    input wire logic               nrm_valid,
    input wire logic               nrm_stall,
    input wire tun_pkg::nrm_word_t nrm_word
);

    // A degenerate word carries a zero normal.
    `TUN_ASSERT_NOW(a_degen_zero, nrm_valid && nrm_word.degenerate, nrm_word.normal_x == '0 && nrm_word.normal_y == '0 && nrm_word.normal_z == '0)

    // A unit vector always has a component of magnitude at least one over root three.
    `TUN_ASSERT_NOW(a_normal_nonzero, nrm_valid && !nrm_word.degenerate, nrm_word.normal_x != '0 || nrm_word.normal_y != '0 || nrm_word.normal_z != '0)

    // An offered input word is held back only when a finished word is blocked at the output.
    `TUN_ASSERT_NOW(a_stall_cause, tri_valid && tri_stall, nrm_valid && nrm_stall)

    // A blocked result word stays offered.
    `TUN_ASSERT_NEXT(a_out_hold, nrm_valid && nrm_stall, nrm_valid)

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tri_valid (tri_valid),
    .tri_stall (tri_stall),
    .nrm_valid (nrm_valid),
    .nrm_stall (nrm_stall),
    .nrm_word  (nrm_word)
);
`default_nettype wire

// File: tb/triangle_unit_normal_tb.sv
// Self-checking testbench for the triangle unit normal block.
// Depends on tun_pkg and on triangle_unit_normal; reads no files.
`default_nettype none
module triangle_unit_normal_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_MAX = (1 << (tun_pkg::COORD_WIDTH - 1)) - 1;
    localparam int COORD_MIN = -(1 << (tun_pkg::COORD_WIDTH - 1));
    localparam int RANDOM_TRIS = 1130;

    // Clock, reset and the block's ports. Every input starts at a known value.
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               tri_valid = 1'b0;
    logic               tri_stall;
    tun_pkg::tri_word_t tri_word = '0;
    logic               nrm_valid;
    logic               nrm_stall = 1'b0;
    tun_pkg::nrm_word_t nrm_word;

    // Triangles waiting to be offered, and the normals still owed by the block.
    tun_pkg::tri_word_t pending_tris[$];
    tun_pkg::nrm_word_t expected_normals[$];

    int  mismatches = 0;
    bit  tri_taken = 1'b0;
    bit  idling_on = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  recv_hold_left = 0;
    int  hold_requests = 0;
    int  holds_served = 0;

    triangle_unit_normal dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_valid (tri_valid),
        .tri_stall (tri_stall),
        .tri_word  (tri_word),
        .nrm_valid (nrm_valid),
        .nrm_stall (nrm_stall),
        .nrm_word  (nrm_word)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Exact unit normal of one triangle. The squared lengths need about 100
    // bits and the compared terms about 132, so the division is done in 256-bit
    // unsigned arithmetic: q is the largest value with
    // (2q-1)^2 * |c|^2 <= c_i^2 * 2^(2F+2), which is the quotient rounded to nearest with ties away from zero.
    function automatic tun_pkg::nrm_word_t unit_normal(input tun_pkg::tri_word_t t);
        longint     edge_v[3];
        longint     edge_w[3];
        longint     cross_c[3];
        logic [255:0] mag[3];
        logic [255:0] len_sq;
        logic [255:0] num;
        logic [255:0] lhs;
        logic [255:0] odd;
        logic [tun_pkg::OUT_W-1:0] comp[3];
        longint     lo;
        longint     hi;
        longint     mid;
        tun_pkg::nrm_word_t r;
        edge_v[0] = longint'(t.second_x) - longint'(t.first_x);
        edge_v[1] = longint'(t.second_y) - longint'(t.first_y);
        edge_v[2] = longint'(t.second_z) - longint'(t.first_z);
        edge_w[0] = longint'(t.third_x) - longint'(t.first_x);
        edge_w[1] = longint'(t.third_y) - longint'(t.first_y);
        edge_w[2] = longint'(t.third_z) - longint'(t.first_z);
        len_sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            cross_c[i] = edge_v[(i + 1) % 3] * edge_w[(i + 2) % 3]
                       - edge_v[(i + 2) % 3] * edge_w[(i + 1) % 3];
            mag[i] = (cross_c[i] < 0) ? 256'(-cross_c[i]) : 256'(cross_c[i]);
            len_sq = len_sq + mag[i] * mag[i];
        end
        r = '0;
        if (len_sq == '0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            num = (mag[i] * mag[i]) << (2 * tun_pkg::NORMAL_FRAC_BITS + 2);
            lo = 0;
            hi = longint'(1) << tun_pkg::NORMAL_FRAC_BITS;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                odd = 256'(2 * mid - 1);
                lhs = odd * odd * len_sq;
                if (lhs <= num)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            if (cross_c[i] < 0)
                comp[i] = tun_pkg::OUT_W'(-lo);
            else if (lo >= (longint'(1) << tun_pkg::NORMAL_FRAC_BITS))
                comp[i] = tun_pkg::OUT_W'((longint'(1) << tun_pkg::NORMAL_FRAC_BITS) - 1);
            else
                comp[i] = tun_pkg::OUT_W'(lo);
        end
        r.normal_x = comp[0];
        r.normal_y = comp[1];
        r.normal_z = comp[2];
        return r;
    endfunction

    function automatic tun_pkg::tri_word_t make_tri(input int ax, ay, az, bx, by, bz,
                                                    cx, cy, cz);
        tun_pkg::tri_word_t t;
        t.first_x  = tun_pkg::COORD_WIDTH'(ax);
        t.first_y  = tun_pkg::COORD_WIDTH'(ay);
        t.first_z  = tun_pkg::COORD_WIDTH'(az);
        t.second_x = tun_pkg::COORD_WIDTH'(bx);
        t.second_y = tun_pkg::COORD_WIDTH'(by);
        t.second_z = tun_pkg::COORD_WIDTH'(bz);
        t.third_x  = tun_pkg::COORD_WIDTH'(cx);
        t.third_y  = tun_pkg::COORD_WIDTH'(cy);
        t.third_z  = tun_pkg::COORD_WIDTH'(cz);
        return t;
    endfunction

    function automatic int any_coord();
        return int'($signed(tun_pkg::COORD_WIDTH'($urandom)));
    endfunction

    function automatic int near_coord(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // One random triangle. Half are ordinary triangles at every scale; the
    // rest are collinear or coincident points, axis-aligned ones whose normal
    // is exactly plus or minus one, and tiny ones where ties in rounding occur.
    function automatic tun_pkg::tri_word_t random_tri();
        int kind;
        int p[9];
        int d[3];
        int k;
        kind = $urandom_range(0, 19);
        if (kind < 8)
        begin
            foreach (p[i]) p[i] = any_coord();
        end
        else if (kind < 11)
        begin
            foreach (p[i]) p[i] = near_coord(6);
        end
        else if (kind < 13)
        begin
            foreach (p[i]) p[i] = near_coord(1 << ($urandom_range(4, 20)));
        end
        else if (kind < 16)
        begin
            // Collinear points, sometimes coincident ones.
            k = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 3; i++)
            begin
                p[i] = near_coord(1 << 20);
                d[i] = ($urandom_range(0, 3) == 0) ? 0 : near_coord(1 << 16);
                p[3 + i] = p[i] + d[i];
                p[6 + i] = p[i] + k * d[i];
            end
        end
        else
        begin
            // All three points share one coordinate: the normal lies on an axis.
            foreach (p[i]) p[i] = any_coord();
            k = $urandom_range(0, 2);
            p[3 + k] = p[k];
            p[6 + k] = p[k];
        end
        return make_tri(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]);
    endfunction

    // Appends one triangle to the pending queue.
    task automatic queue_tri(input tun_pkg::tri_word_t t);
        pending_tris.insert(pending_tris.size(), t);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Driver. A word that was offered but not yet taken stays on the port
    // unchanged; otherwise the next pending triangle goes out unless a random
    // idle burst is running.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            tri_valid <= 1'b0;
        end
        else if (tri_valid && !tri_taken)
        begin
            tri_valid <= 1'b1;
        end
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            tri_valid <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 11) == 0)
        begin
            send_gap <= $urandom_range(0, 18);
            tri_valid <= 1'b0;
        end
        else if (pending_tris.size() > 0)
        begin
            tri_word <= pending_tris.pop_front();
            tri_valid <= 1'b1;
        end
        else
        begin
            tri_valid <= 1'b0;
        end
    end

    // Receiver stall. A requested long hold-off is counted here, in cycles,
    // so that the pipeline fills and pushes back on the input side.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            nrm_stall <= 1'b0;
        end
        else if (holds_served < hold_requests)
        begin
            holds_served <= holds_served + 1;
            recv_hold_left <= 299;
            nrm_stall <= 1'b1;
        end
        else if (recv_hold_left > 0)
        begin
            recv_hold_left <= recv_hold_left - 1;
            nrm_stall <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            nrm_stall <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 11) == 0)
        begin
            recv_gap <= $urandom_range(0, 18);
            nrm_stall <= 1'b1;
        end
        else
        begin
            nrm_stall <= 1'b0;
        end
    end

    // Monitor. Results are checked against the oldest expected normal, and
    // each accepted triangle adds its prediction to the back of the queue.
    always @(posedge clk)
    begin
        tun_pkg::nrm_word_t want;
        if (rst_n)
        begin
            if (nrm_valid && !nrm_stall)
            begin
                if (expected_normals.size() == 0)
                begin
                    report_mismatch("unexpected normal word", 1, 0);
                end
                else
                begin
                    want = expected_normals.pop_front();
                    if (nrm_word.normal_x !== want.normal_x)
                        report_mismatch("normal_x", nrm_word.normal_x, want.normal_x);
                    if (nrm_word.normal_y !== want.normal_y)
                        report_mismatch("normal_y", nrm_word.normal_y, want.normal_y);
                    if (nrm_word.normal_z !== want.normal_z)
                        report_mismatch("normal_z", nrm_word.normal_z, want.normal_z);
                    if (nrm_word.degenerate !== want.degenerate)
                        report_mismatch("degenerate", nrm_word.degenerate,
                                        want.degenerate);
                end
            end
            tri_taken <= tri_valid && !tri_stall;
            if (tri_valid && !tri_stall)
                expected_normals.insert(expected_normals.size(), unit_normal(tri_word));
        end
    end

    task automatic wait_sent();
        while (pending_tris.size() > 0 || tri_valid)
            @(posedge clk);
    endtask

    // Stimulus sequence: directed triangles, two random phases, the first with
    // a long receiver hold-off, with a full drain in between, then a final
    // phase with no idling on either side.
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Coincident points and collinear points.
        queue_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_tri(make_tri(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
                           COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                           COORD_MAX));
        queue_tri(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
        queue_tri(make_tri(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0,
                           COORD_MAX, COORD_MAX, COORD_MAX));
        // Normals of exactly +1 saturate; exactly -1 is representable.
        queue_tri(make_tri(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
                           COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
                           COORD_MIN));
        queue_tri(make_tri(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                           COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                           COORD_MIN));
        queue_tri(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
        queue_tri(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0));
        queue_tri(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
        queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
        // Extreme coordinates in mixed combinations.
        queue_tri(make_tri(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                           COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                           COORD_MAX));
        queue_tri(make_tri(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                           COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                           COORD_MIN));
        queue_tri(make_tri(COORD_MAX, COORD_MIN, 0, COORD_MIN, 0,
                           COORD_MAX, 0, COORD_MAX, COORD_MIN));
        queue_tri(make_tri(-1, -1, -1, 0, 0, 0, 1, -1, 0));
        queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 1));
        queue_tri(make_tri(0, 0, 0, 1, 2, 3, 4, 5, 7));
        queue_tri(make_tri(5, -3, 2, 5, -3, 2, 9, 9, 9));
        wait_sent();

        // Random traffic with idling on both sides.
        idling_on = 1'b1;
        for (int i = 0; i < RANDOM_TRIS / 3; i++)
            queue_tri(random_tri());
        repeat (200) @(posedge clk);
        hold_requests = hold_requests + 1;
        wait_sent();

        // Let every expected normal arrive before offering more.
        while (expected_normals.size() > 0)
            @(posedge clk);
        for (int i = 0; i < RANDOM_TRIS / 3; i++)
            queue_tri(random_tri());
        wait_sent();

        // Final stretch at full rate.
        idling_on = 1'b0;
        for (int i = 0; i < RANDOM_TRIS - 2 * (RANDOM_TRIS / 3); i++)
            queue_tri(random_tri());
        wait_sent();
        while (expected_normals.size() > 0 || recv_gap > 0 || send_gap > 0)
            @(posedge clk);
        repeat (tun_pkg::NUM_STAGES + 10) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
